// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop on every rising edge of clk, skipped while rst is high.
`define SBM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop on every rising edge of clk, reset included.
`define SBM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBM_ASSERT(label, clk, rst, prop, msg)
`define SBM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hdl/sbm_pkg.sv =====
package sbm_pkg;

  localparam int MAX_LEVELS_DEF = 32;
  localparam int CHANNELS_DEF   = 2;

  localparam int LEVEL_W     = 16;
  localparam int INDEX_W     = 5;
  localparam int OUT_INDEX_W = 5;
  localparam int TICKS_W     = 16;
  localparam int LIU_W       = 6;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVELS_IN_USE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TICKS    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FALL_TICKS    = 2'd2;

  localparam logic [LIU_W-1:0]   LEVELS_IN_USE_RST = 6'd32;
  localparam logic [TICKS_W-1:0] HOLD_TICKS_RST    = 16'd20;
  localparam logic [TICKS_W-1:0] FALL_TICKS_RST    = 16'd4;

  // request kinds
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic take_item;
    logic table_write;
    logic search_step;
    logic apply;
    logic result_load;
  } sbm_cmd_t;

  typedef struct packed {
    logic search_done;
    logic out_free;
  } sbm_status_t;

endpackage

// ===== hdl/sbm_ctrl.sv =====
`include "assert_macros.svh"

module sbm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                command,
  input  sbm_pkg::sbm_status_t status,
  output sbm_pkg::sbm_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_APPLY  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (command == sbm_pkg::CMD_LOAD) begin
            cmd.table_write = 1'b1;
            state_next      = ST_RESULT;
          end else begin
            cmd.take_item = 1'b1;
            state_next    = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (status.search_done) begin
          state_next = ST_APPLY;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SBM_ASSERT(a_load_needs_room, clk, rst, cmd.result_load |-> status.out_free, "result loaded while output busy")
  `SBM_ASSERT(a_apply_after_search, clk, rst, cmd.apply |-> status.search_done, "apply before search finished")
  `SBM_ASSERT(a_accept_one_kind, clk, rst, (s_tvalid && s_tready) |-> (cmd.take_item || cmd.table_write), "accepted request not acted on")

endmodule

// ===== hdl/sbm_dp.sv =====
`include "assert_macros.svh"

module sbm_dp #(
  parameter int MAX_LEVELS = sbm_pkg::MAX_LEVELS_DEF,
  parameter int CHANNELS   = sbm_pkg::CHANNELS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sbm_pkg::sbm_cmd_t                       cmd,
  output sbm_pkg::sbm_status_t                    status,
  input  logic                                    cfg_we,
  input  logic [sbm_pkg::CFG_ADDR_W-1:0]          cfg_addr,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic [sbm_pkg::INDEX_W-1:0]             entry_index,
  input  logic signed [sbm_pkg::LEVEL_W-1:0]      entry_threshold,
  input  logic signed [sbm_pkg::LEVEL_W-1:0]      level_left,
  input  logic signed [sbm_pkg::LEVEL_W-1:0]      level_right,
  input  logic                                    m_tready,
  output logic                                    m_tvalid,
  output logic [sbm_pkg::OUT_INDEX_W-1:0]         bar_left,
  output logic [sbm_pkg::OUT_INDEX_W-1:0]         bar_right,
  output logic [sbm_pkg::OUT_INDEX_W-1:0]         dot_left,
  output logic [sbm_pkg::OUT_INDEX_W-1:0]         dot_right
);

  localparam int LW = $clog2(MAX_LEVELS);
  localparam int CW = $clog2(MAX_LEVELS + 1);
  localparam int TW = sbm_pkg::TICKS_W;

  // configuration
  logic [sbm_pkg::LIU_W-1:0] levels_in_use;
  logic [TW-1:0]             hold_ticks;
  logic [TW-1:0]             fall_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= sbm_pkg::LEVELS_IN_USE_RST;
      hold_ticks    <= sbm_pkg::HOLD_TICKS_RST;
      fall_ticks    <= sbm_pkg::FALL_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        sbm_pkg::CFG_LEVELS_IN_USE: levels_in_use <= cfg_data[sbm_pkg::LIU_W-1:0];
        sbm_pkg::CFG_HOLD_TICKS:    hold_ticks    <= cfg_data[TW-1:0];
        sbm_pkg::CFG_FALL_TICKS:    fall_ticks    <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // threshold memory
  logic signed [sbm_pkg::LEVEL_W-1:0] thr_mem [MAX_LEVELS];
  logic signed [sbm_pkg::LEVEL_W-1:0] rd_data;
  logic                               wr_ok;

  assign wr_ok = (32'(entry_index) < MAX_LEVELS);

  always_ff @(posedge clk) begin
    if (cmd.table_write && wr_ok) begin
      thr_mem[LW'(entry_index)] <= entry_threshold;
    end
  end

  // search sequencer: one table entry read per cycle, compared in the following cycle
  logic [CW-1:0] cnt;
  logic [CW-1:0] n_lim;
  logic          issuing;
  logic          pend_valid;
  logic [LW-1:0] pend_idx;

  assign n_lim   = (32'(levels_in_use) > MAX_LEVELS) ? CW'(MAX_LEVELS) : CW'(levels_in_use);
  assign issuing = (cnt < n_lim);

  always_ff @(posedge clk) begin
    if (cmd.search_step && issuing) begin
      rd_data  <= thr_mem[cnt[LW-1:0]];
      pend_idx <= cnt[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.search_step && issuing;
      if (cmd.take_item) begin
        cnt <= '0;
      end else if (cmd.search_step && issuing) begin
        cnt <= CW'(cnt + 1'b1);
      end
    end
  end

  assign status.search_done = !issuing && !pend_valid;

  // per-channel lanes
  logic signed [sbm_pkg::LEVEL_W-1:0] lvl [CHANNELS];
  logic [CHANNELS-1:0]                found;
  logic [LW-1:0]                      hit [CHANNELS];

  logic [LW-1:0]       bar [CHANNELS];
  logic [LW-1:0]       dot [CHANNELS];
  logic [TW-1:0]       hold_cnt [CHANNELS];
  logic [TW-1:0]       fall_cnt [CHANNELS];
  logic [CHANNELS-1:0] falling;

  logic [LW-1:0]       bar_next [CHANNELS];
  logic [LW-1:0]       dot_next [CHANNELS];
  logic [TW-1:0]       hold_cnt_next [CHANNELS];
  logic [TW-1:0]       fall_cnt_next [CHANNELS];
  logic [CHANNELS-1:0] falling_next;

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (cmd.take_item) begin
        lvl[ch] <= (ch == 0) ? level_left : level_right;
      end
      if (pend_valid && !found[ch] && (lvl[ch] <= rd_data)) begin
        hit[ch] <= pend_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= '0;
    end else begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (cmd.take_item) begin
          found[ch] <= 1'b0;
        end else if (pend_valid && (lvl[ch] <= rd_data)) begin
          found[ch] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      bar_next[ch]      = found[ch] ? hit[ch] : bar[ch];
      dot_next[ch]      = dot[ch];
      hold_cnt_next[ch] = hold_cnt[ch];
      fall_cnt_next[ch] = fall_cnt[ch];
      falling_next[ch]  = falling[ch];
      // jump the dot up to a new peak and restart the hold
      if (found[ch] && (hit[ch] > dot[ch])) begin
        dot_next[ch]      = hit[ch];
        hold_cnt_next[ch] = '0;
        fall_cnt_next[ch] = '0;
        falling_next[ch]  = 1'b0;
      end
      if (falling_next[ch]) begin
        fall_cnt_next[ch] = TW'(fall_cnt_next[ch] + 1'b1);
        if (fall_cnt_next[ch] >= fall_ticks) begin
          fall_cnt_next[ch] = '0;
          if (dot_next[ch] != '0) begin
            dot_next[ch] = LW'(dot_next[ch] - 1'b1);
          end
        end
      end else begin
        hold_cnt_next[ch] = TW'(hold_cnt_next[ch] + 1'b1);
        if (hold_cnt_next[ch] >= hold_ticks) begin
          hold_cnt_next[ch] = '0;
          falling_next[ch]  = 1'b1;
          if (dot_next[ch] != '0) begin
            dot_next[ch] = LW'(dot_next[ch] - 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        bar[ch]      <= '0;
        dot[ch]      <= '0;
        hold_cnt[ch] <= '0;
        fall_cnt[ch] <= '0;
      end
      falling <= '0;
    end else if (cmd.apply) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        bar[ch]      <= bar_next[ch];
        dot[ch]      <= dot_next[ch];
        hold_cnt[ch] <= hold_cnt_next[ch];
        fall_cnt[ch] <= fall_cnt_next[ch];
      end
      falling <= falling_next;
    end
  end

  // output register
  logic [sbm_pkg::OUT_INDEX_W-1:0] rep_bar_right;
  logic [sbm_pkg::OUT_INDEX_W-1:0] rep_dot_right;

  generate
    if (CHANNELS > 1) begin : g_right
      assign rep_bar_right = sbm_pkg::OUT_INDEX_W'(bar[1]);
      assign rep_dot_right = sbm_pkg::OUT_INDEX_W'(dot[1]);
    end else begin : g_no_right
      assign rep_bar_right = '0;
      assign rep_dot_right = '0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      bar_left  <= sbm_pkg::OUT_INDEX_W'(bar[0]);
      dot_left  <= sbm_pkg::OUT_INDEX_W'(dot[0]);
      bar_right <= rep_bar_right;
      dot_right <= rep_dot_right;
    end
  end

  assign status.out_free = !m_tvalid || m_tready;

  `SBM_ASSERT(a_pend_after_issue, clk, rst, pend_valid |-> (cnt != '0), "compare without an issued read")
  `SBM_ASSERT(a_valid_from_load, clk, rst, $rose(m_tvalid) |-> $past(cmd.result_load), "result appeared without a load")
  `SBM_ASSERT(a_no_issue_past_end, clk, rst, (cmd.search_step && issuing) |-> (cnt < n_lim), "read issued beyond searched levels")

endmodule

// ===== hdl/stereo_bar_meter_peak_hold_unit.sv =====
// Channel   Dir  Handshake            Contents
// s_*       in   s_tvalid/s_tready    load or update request
// m_*       out  m_tvalid/m_tready    bar and dot indexes, one per request
// cfg_*     in   cfg_we               levels_in_use, hold_ticks, fall_ticks
//
// A load goes from acceptance to the result state; an update passes the search,
// apply and result states, searching n = min(levels_in_use, MAX_LEVELS) entries:
// the one threshold memory read port gives one entry per cycle to all channels.
// Reset (rst, synchronous) clears the meter state and the registers; the
// threshold table is not cleared. A result waiting on m_tready stalls only
// the request after next; the next request is taken meanwhile.
module stereo_bar_meter_peak_hold_unit #(
  parameter int MAX_LEVELS = sbm_pkg::MAX_LEVELS_DEF,
  parameter int CHANNELS   = sbm_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // entry_index[4:0], entry_threshold[20:5], level_left[36:21],
  // level_right[52:37], zeros above
  input  logic [sbm_pkg::IN_TDATA_W-1:0]    s_tdata,
  // command[0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // bar_left[4:0], bar_right[9:5], dot_left[14:10], dot_right[19:15], zeros above
  output logic [sbm_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_we,
  input  logic [sbm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sbm_pkg::sbm_cmd_t    cmd;
  sbm_pkg::sbm_status_t status;

  logic [sbm_pkg::INDEX_W-1:0]        entry_index;
  logic signed [sbm_pkg::LEVEL_W-1:0] entry_threshold;
  logic signed [sbm_pkg::LEVEL_W-1:0] level_left;
  logic signed [sbm_pkg::LEVEL_W-1:0] level_right;

  logic [sbm_pkg::OUT_INDEX_W-1:0] bar_left;
  logic [sbm_pkg::OUT_INDEX_W-1:0] bar_right;
  logic [sbm_pkg::OUT_INDEX_W-1:0] dot_left;
  logic [sbm_pkg::OUT_INDEX_W-1:0] dot_right;

  assign entry_index     = s_tdata[4:0];
  assign entry_threshold = s_tdata[20:5];
  assign level_left      = s_tdata[36:21];
  assign level_right     = s_tdata[52:37];

  assign m_tdata = {4'd0, dot_right, dot_left, bar_right, bar_left};

  sbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  sbm_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .CHANNELS   (CHANNELS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .entry_index     (entry_index),
    .entry_threshold (entry_threshold),
    .level_left      (level_left),
    .level_right     (level_right),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .bar_left        (bar_left),
    .bar_right       (bar_right),
    .dot_left        (dot_left),
    .dot_right       (dot_right)
  );

endmodule
